/* src/skvt_pkg.sv */
package skvt_pkg;

  // table geometry
  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;

  // request codes
  localparam logic [1:0] REQ_SET = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_BADKEY = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;
  } skvt_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
  } skvt_rsp_t;

  // slot memory access from the controller
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_val;
  } skvt_mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
  } skvt_mem_rsp_t;

endpackage

/* src/small_key_value_slot_table_core.sv */
// Key/value slot table with SLOTS entries of 64-bit key and 64-bit value; a
// zero key marks an empty slot. A request (set, get or delete) is taken when
// start is high and busy is low, and exactly one result follows on rsp_o,
// valid for the single cycle in which done_o is high. The receiver cannot
// stall: the result must be taken in that cycle. Every request runs a full
// scan that reads one slot per cycle from the slot memory through its
// registered read port, followed by a finish state for the write-back and
// the result. busy stays high until the result cycle ends.
module small_key_value_slot_table_core
  import skvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  skvt_req_t req_i,
  output logic      busy,
  output logic      done_o,
  output skvt_rsp_t rsp_o
);

  // controller to memory transfer and read data back
  skvt_mem_req_t mem_req;
  skvt_mem_rsp_t mem_rsp;

  // scan sequencer: issues reads, tracks first match and first empty slot,
  // then writes back and presents the result
  skvt_scan_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .req_i     (req_i),
    .busy      (busy),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp)
  );

  // slot storage with a registered read port, empty after reset
  skvt_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .mem_rsp_o (mem_rsp)
  );

`ifndef NO_ASSERTIONS
  // result cycle always returns the block to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after result");

  // an accepted request never answers in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted request did not start a scan");

  // slot writes happen only in the result cycle
  a_write_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> done_o)
    else $error("slot write outside result cycle");

  // failed requests return a zero value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.read_value == '0))
    else $error("nonzero value on failed request");
`endif

endmodule

/* src/skvt_slot_mem.sv */
module skvt_slot_mem
  import skvt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  skvt_mem_req_t mem_req_i,
  output skvt_mem_rsp_t mem_rsp_o
);

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0] valid_q;

  logic [KEY_W-1:0] rd_key_q;
  logic [VAL_W-1:0] rd_val_q;
  logic             rd_vld_q;

  // storage and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      key_mem[mem_req_i.wr_addr] <= mem_req_i.wr_key;
      val_mem[mem_req_i.wr_addr] <= mem_req_i.wr_val;
    end
    if (mem_req_i.rd_en) begin
      rd_key_q <= key_mem[mem_req_i.rd_addr];
      rd_val_q <= val_mem[mem_req_i.rd_addr];
    end
  end

  // never-written slots read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_req_i.wr_en) begin
        valid_q[mem_req_i.wr_addr] <= 1'b1;
      end
      if (mem_req_i.rd_en) begin
        rd_vld_q <= valid_q[mem_req_i.rd_addr];
      end
    end
  end

  assign mem_rsp_o.rd_key = rd_vld_q ? rd_key_q : '0;
  assign mem_rsp_o.rd_val = rd_vld_q ? rd_val_q : '0;

endmodule

/* src/skvt_scan_ctrl.sv */
module skvt_scan_ctrl
  import skvt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  skvt_req_t     req_i,
  output logic          busy,
  output logic          done_o,
  output skvt_rsp_t     rsp_o,
  output skvt_mem_req_t mem_req_o,
  input  skvt_mem_rsp_t mem_rsp_i
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  skvt_req_t        req_q, req_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [VAL_W-1:0] hit_val_q, hit_val_d;
  logic             empty_q, empty_d;
  logic [IDX_W-1:0] empty_idx_q, empty_idx_d;

  logic issue;
  logic key_zero;

  assign issue    = (cnt_q != CNT_W'(SLOTS));
  assign key_zero = (req_q.lookup_key == '0);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    rd_pend_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    hit_idx_d   = hit_idx_q;
    hit_val_d   = hit_val_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;

    mem_req_o         = '0;
    mem_req_o.rd_addr = cnt_q[IDX_W-1:0];

    done_o           = 1'b0;
    rsp_o.status     = ST_MISS;
    rsp_o.read_value = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          cnt_d   = '0;
          found_d = 1'b0;
          empty_d = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one read per cycle and compare the data that the registered read returns
        if (issue) begin
          mem_req_o.rd_en = 1'b1;
          rd_pend_d       = 1'b1;
          cmp_idx_d       = cnt_q[IDX_W-1:0];
          cnt_d           = cnt_q + CNT_W'(1);
        end else begin
          state_d = S_FINISH;
        end
        if (rd_pend_q) begin
          if (mem_rsp_i.rd_key == req_q.lookup_key && !found_q) begin
            found_d   = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_val_d = mem_rsp_i.rd_val;
          end
          if (mem_rsp_i.rd_key == '0 && !empty_q) begin
            empty_d     = 1'b1;
            empty_idx_d = cmp_idx_q;
          end
        end
      end

      S_FINISH: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
        if (key_zero) begin
          rsp_o.status = ST_BADKEY;
        end else begin
          unique case (req_q.req_type)
            REQ_SET: begin
              if (found_q || empty_q) begin
                rsp_o.status      = ST_OK;
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = found_q ? hit_idx_q : empty_idx_q;
                mem_req_o.wr_key  = req_q.lookup_key;
                mem_req_o.wr_val  = req_q.write_value;
              end
            end
            REQ_GET: begin
              if (found_q) begin
                rsp_o.status     = ST_OK;
                rsp_o.read_value = hit_val_q;
              end
            end
            REQ_DEL: begin
              if (found_q) begin
                rsp_o.status      = ST_OK;
                rsp_o.read_value  = hit_val_q;
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = hit_idx_q;
              end
            end
            default: begin
              rsp_o.status = ST_MISS;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      empty_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      found_q   <= found_d;
      empty_q   <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    cmp_idx_q   <= cmp_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_val_q   <= hit_val_d;
    empty_idx_q <= empty_idx_d;
  end

endmodule
